// ===== hw/rtl/vrld_pkg.sv =====
// Package: shared types, constants and helpers of the visibility row decoder.
`default_nettype none

package vrld_pkg;

    localparam int VIS_BYTE_W     = 8;
    localparam int LEAF_IDX_W     = 16;
    localparam int CFG_W          = 15;
    localparam int COUNT_SHIFT    = 3;
    localparam int LEAFS_PER_BYTE = 8;
    localparam int POS_W          = 3;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } vrld_state_t;

    // Position of the lowest set bit of a byte (0 when the byte is zero).
    function automatic logic [POS_W-1:0] lowest_set(input logic [VIS_BYTE_W-1:0] m);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int i = VIS_BYTE_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                pos = POS_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vrld_in_if.sv =====
// Interface: input channel carrying one coded visibility byte per beat.
`default_nettype none

interface vrld_in_if
    import vrld_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [VIS_BYTE_W-1:0] vis_byte;
    logic                  row_start;

    modport source (output valid, output vis_byte, output row_start, input ready);
    modport sink   (input valid, input vis_byte, input row_start, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vrld_out_if.sv =====
// Interface: output channel carrying one visible leaf index per beat.
`default_nettype none

interface vrld_out_if
    import vrld_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [LEAF_IDX_W-1:0] leaf_index;
    logic                  last_of_item;

    modport source (output valid, output leaf_index, output last_of_item, input ready);
    modport sink   (input valid, input leaf_index, input last_of_item, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/visibility_rle_leaf_decoder_top.sv =====
// Top level: run-length coded visibility row decoder, one byte in, leaf indices out.
//
//  channel   dir  handshake         beat contents
//  in_ch     in   valid/ready       vis_byte[7:0], row_start
//  out_ch    out  valid/ready       leaf_index[15:0], last_of_item
//  cfg       in   cfg_wr_en only    cfg_wr_data[14:0] -> num_vis_leafs
//
// Bytes: a byte that emits nothing (idle row, finished row, zero marker,
//   count byte) is handled in ST_IDLE. A nonzero byte goes on to ST_EMIT,
//   where one saturating adder gives one leaf index per set bit, one per cycle unless out_ch stalls.
// Reset: rst_n is asynchronous; counter returns to 1, no row open, no clear pass.
// Stalls: the output register holds a beat while out_ch.ready is low; the
//   emit sequencer waits on it, and in_ch.ready is high only when idle.
`default_nettype none

module visibility_rle_leaf_decoder_top
    import vrld_pkg::*;
#(
    parameter int LEAF_BITS = 15
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    vrld_in_if.sink               in_ch,
    vrld_out_if.source            out_ch,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data
);

    // Counter holds LEAF_BITS+2 bits; sum width covers counter + count*8.
    localparam int CNT_W = LEAF_BITS + 2;
    localparam int SUM_W = LEAF_BITS + 4;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    vrld_state_t            state_reg, state_next;
    logic [LEAF_BITS-1:0]   nvl_reg;
    logic [CNT_W-1:0]       counter_reg, counter_next;
    logic                   expect_reg, expect_next;
    logic                   active_reg, active_next;
    logic [CNT_W-1:0]       base_reg, base_next;
    logic [VIS_BYTE_W-1:0]  mask_reg, mask_next;
    logic                   out_valid_reg, out_valid_next;
    logic [LEAF_IDX_W-1:0]  index_reg, index_next;
    logic                   last_reg, last_next;

    // Row state as seen by the incoming byte (a row start restarts it).
    logic                   in_accept;
    logic [CNT_W-1:0]       cnt_eff;
    logic                   exp_eff;
    logic                   act_eff;
    logic                   row_done;

    // Shared saturating adder.
    logic [SUM_W-1:0]       add_a, add_b, add_sum;
    logic [CNT_W-1:0]       add_sat;

    logic [POS_W-1:0]       bit_pos;
    logic [VIS_BYTE_W-1:0]  mask_rest;
    logic                   emit_last;
    logic                   out_free;
    logic                   emit_load;

    assign in_ch.ready         = (state_reg == ST_IDLE);
    assign in_accept           = in_ch.valid && in_ch.ready;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.leaf_index   = index_reg;
    assign out_ch.last_of_item = last_reg;

    assign cnt_eff  = in_ch.row_start ? CNT_W'(1) : counter_reg;
    assign exp_eff  = in_ch.row_start ? 1'b0 : expect_reg;
    assign act_eff  = in_ch.row_start || active_reg;
    assign row_done = (cnt_eff >= CNT_W'(nvl_reg));

    assign bit_pos   = lowest_set(mask_reg);
    assign mask_rest = mask_reg & (mask_reg - VIS_BYTE_W'(1));
    assign emit_last = (mask_rest == '0);
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign emit_load = (state_reg == ST_EMIT) && out_free;

    // Operand select: leaf offset while emitting, count*8 or 8 on accept.
    always_comb
    begin
        if (state_reg == ST_EMIT)
        begin
            add_a = SUM_W'(base_reg);
            add_b = SUM_W'(bit_pos);
        end
        else
        begin
            add_a = SUM_W'(cnt_eff);
            if (exp_eff)
            begin
                add_b = SUM_W'(in_ch.vis_byte) << COUNT_SHIFT;
            end
            else
            begin
                add_b = SUM_W'(LEAFS_PER_BYTE);
            end
        end
        add_sum = add_a + add_b;
        add_sat = (add_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(add_sum);
    end

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        counter_next   = counter_reg;
        expect_next    = expect_reg;
        active_next    = active_reg;
        base_next      = base_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        index_next     = index_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    counter_next = cnt_eff;
                    expect_next  = exp_eff;
                    active_next  = act_eff;
                    if (!act_eff)
                    begin
                        // no open row: byte dropped
                    end
                    else if (exp_eff)
                    begin
                        // run of empty bytes
                        counter_next = add_sat;
                        expect_next  = 1'b0;
                    end
                    else if (row_done)
                    begin
                        active_next = 1'b0;
                    end
                    else if (in_ch.vis_byte == '0)
                    begin
                        expect_next = 1'b1;
                    end
                    else
                    begin
                        base_next    = cnt_eff;
                        counter_next = add_sat;
                        mask_next    = in_ch.vis_byte;
                        state_next   = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    index_next     = LEAF_IDX_W'(add_sat);
                    last_next      = emit_last;
                    mask_next      = mask_rest;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nvl_reg       <= '0;
            counter_reg   <= CNT_W'(1);
            expect_reg    <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            expect_reg    <= expect_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                nvl_reg <= LEAF_BITS'(cfg_wr_data);
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        mask_reg  <= mask_next;
        index_reg <= index_next;
        last_reg  <= last_next;
    end

`ifndef ASSERT_OFF
    a_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> mask_reg != '0)
        else $error("emit state with empty bit mask");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load && emit_last |=> state_reg == ST_IDLE && out_ch.last_of_item)
        else $error("last index did not end the byte");

    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        counter_reg != '0)
        else $error("leaf counter reached zero");

    a_expect_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        expect_reg |-> active_reg)
        else $error("count byte pending outside a row");
`endif

endmodule

`default_nettype wire
